[design/tlr_pkg.sv]
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types and constants for the thick line rasterizer: opcodes,
// register indexes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package tlr_pkg;

  localparam int PIX_W = 16;   // output coordinate and color width
  localparam int CFG_W = 13;   // screen size register width
  localparam int PEN_W = 3;    // pen width field

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd600;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_EMIT = 3'b100
  } tlr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_start;  // latch a new line and seed the brush walk
    logic load_step;   // one Bresenham step, seed the brush walk
    logic first;       // first brush pixel of the transaction
    logic load_pix;    // register a pixel and advance the brush walk
  } tlr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic active;      // a line is in progress
    logic last;        // output register holds the final brush pixel
  } tlr_stat_t;

endpackage

[design/tlr_ctrl.sv]
// ----------------------------------------------------------------------------
// tlr_ctrl
// Sequencer: takes one transaction, lets the datapath prepare the first
// brush pixel, then hands out one pixel per cycle while out_stall is low, until the last is taken.
// ----------------------------------------------------------------------------
module tlr_ctrl import tlr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_operation,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  tlr_stat_t stat,
  output tlr_cmd_t  cmd
);

  tlr_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_operation == OP_START) begin
            cmd.load_start = 1'b1;
            state_nxt      = ST_PREP;
          end else if (stat.active) begin
            cmd.load_step = 1'b1;
            state_nxt     = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.load_pix = 1'b1;
        cmd.first    = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (stat.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.load_pix = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/tlr_datapath.sv]
// ----------------------------------------------------------------------------
// tlr_datapath
// Line state, Bresenham step, brush offset counters, clip compare and the
// output pixel register. Screen size registers live here as well.
// ----------------------------------------------------------------------------
module tlr_datapath import tlr_pkg::*; #(
  parameter int COORD_BITS     = 12,
  parameter int MAX_BRUSH_HALF = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  logic [PIX_W-1:0]      in_pen_color,
  input  logic [PEN_W-1:0]      in_pen_width,
  input  tlr_cmd_t              cmd,
  output tlr_stat_t             stat,
  output logic [PIX_W-1:0]      out_pixel_x,
  output logic [PIX_W-1:0]      out_pixel_y,
  output logic [PIX_W-1:0]      out_pixel_color,
  output logic                  out_visible,
  output logic                  out_last_of_item,
  output logic                  out_line_done
);

  localparam int HALF_W = (MAX_BRUSH_HALF < 2) ? 1 : $clog2(MAX_BRUSH_HALF + 1);
  localparam int OFF_W  = HALF_W + 1;
  localparam int ERR_W  = COORD_BITS + 2;

  logic [CFG_W-1:0]      scr_w_r, scr_h_r;
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r, dlt_x_r, dlt_y_r;
  logic [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt, tgt_x_nxt, tgt_y_nxt, dlt_x_nxt, dlt_y_nxt;
  logic                  neg_x_r, neg_y_r, neg_x_nxt, neg_y_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [PIX_W-1:0]      color_r, color_nxt;
  logic [HALF_W-1:0]     half_r, half_nxt;
  logic                  active_r, active_nxt;
  logic signed [OFF_W-1:0] off_x_r, off_y_r, off_x_nxt, off_y_nxt;

  logic [PIX_W-1:0] px_r, py_r, px_nxt, py_nxt;
  logic             vis_r, last_r, done_r, vis_nxt, last_nxt, done_nxt;

  // brush half from the pen width: 0 and 1 give 0, saturate at the max
  logic [1:0]        half_raw;
  logic [HALF_W-1:0] half_in;
  assign half_raw = in_pen_width[2:1];
  assign half_in  = (32'(half_raw) > MAX_BRUSH_HALF) ? HALF_W'(MAX_BRUSH_HALF)
                                                     : HALF_W'(half_raw);

  // Bresenham step terms
  logic signed [ERR_W:0] e2, dx_s, dy_s;
  logic                  move_x, move_y;
  assign e2     = {err_r, 1'b0};
  assign dx_s   = $signed({3'b000, dlt_x_r});
  assign dy_s   = $signed({3'b000, dlt_y_r});
  assign move_x = e2 > -dy_s;
  assign move_y = e2 < dx_s;

  logic [HALF_W-1:0] walk_half;
  logic              walk_end_x, walk_end_y, at_target;
  assign walk_half  = half_r;
  assign walk_end_x = off_x_r == $signed({1'b0, walk_half});
  assign walk_end_y = off_y_r == $signed({1'b0, walk_half});
  assign at_target  = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    tgt_x_nxt = tgt_x_r;
    tgt_y_nxt = tgt_y_r;
    dlt_x_nxt = dlt_x_r;
    dlt_y_nxt = dlt_y_r;
    neg_x_nxt = neg_x_r;
    neg_y_nxt = neg_y_r;
    err_nxt   = err_r;
    color_nxt = color_r;
    half_nxt  = half_r;
    active_nxt = active_r;
    off_x_nxt = off_x_r;
    off_y_nxt = off_y_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    vis_nxt   = vis_r;
    last_nxt  = last_r;
    done_nxt  = done_r;

    if (cmd.load_start) begin
      cur_x_nxt = in_start_x;
      cur_y_nxt = in_start_y;
      tgt_x_nxt = in_end_x;
      tgt_y_nxt = in_end_y;
      neg_x_nxt = !(in_start_x < in_end_x);
      neg_y_nxt = !(in_start_y < in_end_y);
      dlt_x_nxt = (in_end_x > in_start_x) ? in_end_x - in_start_x : in_start_x - in_end_x;
      dlt_y_nxt = (in_end_y > in_start_y) ? in_end_y - in_start_y : in_start_y - in_end_y;
      err_nxt   = $signed(ERR_W'(dlt_x_nxt)) - $signed(ERR_W'(dlt_y_nxt));
      color_nxt = in_pen_color;
      half_nxt  = half_in;
      off_x_nxt = -$signed({1'b0, half_in});
      off_y_nxt = -$signed({1'b0, half_in});
    end else if (cmd.load_step) begin
      if (move_x) begin
        cur_x_nxt = neg_x_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
      end
      if (move_y) begin
        cur_y_nxt = neg_y_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
      end
      err_nxt = ERR_W'(err_r - (move_x ? dy_s : '0) + (move_y ? dx_s : '0));
      off_x_nxt = -$signed({1'b0, half_r});
      off_y_nxt = -$signed({1'b0, half_r});
    end

    if (cmd.load_pix) begin
      px_nxt   = PIX_W'(cur_x_r) + {{(PIX_W-OFF_W){off_x_r[OFF_W-1]}}, off_x_r};
      py_nxt   = PIX_W'(cur_y_r) + {{(PIX_W-OFF_W){off_y_r[OFF_W-1]}}, off_y_r};
      vis_nxt  = (px_nxt < PIX_W'(scr_w_r)) && (py_nxt < PIX_W'(scr_h_r));
      last_nxt = walk_end_x && walk_end_y;
      done_nxt = at_target;
      // raster walk: columns inner, rows outer
      if (walk_end_x) begin
        off_x_nxt = -$signed({1'b0, half_r});
        off_y_nxt = off_y_r + 1'b1;
      end else begin
        off_x_nxt = off_x_r + 1'b1;
      end
    end
    if (cmd.first) begin
      active_nxt = !at_target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r  <= SCREEN_WIDTH_RST;
      scr_h_r  <= SCREEN_HEIGHT_RST;
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  scr_w_r <= cfg_wr_data;
          REG_SCREEN_HEIGHT: scr_h_r <= cfg_wr_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    tgt_x_r <= tgt_x_nxt;
    tgt_y_r <= tgt_y_nxt;
    dlt_x_r <= dlt_x_nxt;
    dlt_y_r <= dlt_y_nxt;
    neg_x_r <= neg_x_nxt;
    neg_y_r <= neg_y_nxt;
    err_r   <= err_nxt;
    color_r <= color_nxt;
    half_r  <= half_nxt;
    off_x_r <= off_x_nxt;
    off_y_r <= off_y_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    vis_r   <= vis_nxt;
    last_r  <= last_nxt;
    done_r  <= done_nxt;
  end

  assign stat.active      = active_r;
  assign stat.last        = last_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_pixel_color  = color_r;
  assign out_visible      = vis_r;
  assign out_last_of_item = last_r;
  assign out_line_done    = done_r;

endmodule

[design/thick_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// thick_line_rasterizer
// Bresenham line stepper with a square brush; emits one pixel per cycle while out_stall is low.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | operation, endpoints, color, width
//   out_    | output    | out_valid/out_stall | pixel x/y, color, visible, flags
//   cfg_    | input     | cfg_wr_en           | cfg_index, cfg_wr_data
//
// A start or step transaction is accepted in ST_IDLE; ST_PREP registers the
// first brush pixel, then ST_EMIT shows the (2h+1)^2 pixels, h = brush half,
// one per cycle unless stalled, as the offset walk feeds the output register.
// A step with no active line is accepted and emits nothing.
// in_stall is high from acceptance until the last pixel is taken; out_stall
// holds the current pixel. Synchronous active-low reset; no line active.
// ----------------------------------------------------------------------------
module thick_line_rasterizer import tlr_pkg::*; #(
  parameter int COORD_BITS     = 12,
  parameter int MAX_BRUSH_HALF = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  input  logic [PIX_W-1:0]      in_pen_color,
  input  logic [PEN_W-1:0]      in_pen_width,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_pixel_x,
  output logic [PIX_W-1:0]      out_pixel_y,
  output logic [PIX_W-1:0]      out_pixel_color,
  output logic                  out_visible,
  output logic                  out_last_of_item,
  output logic                  out_line_done
);

  tlr_cmd_t  cmd;
  tlr_stat_t stat;

  tlr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  tlr_datapath #(
    .COORD_BITS     (COORD_BITS),
    .MAX_BRUSH_HALF (MAX_BRUSH_HALF)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_pen_color     (in_pen_color),
    .in_pen_width     (in_pen_width),
    .cmd              (cmd),
    .stat             (stat),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_color  (out_pixel_color),
    .out_visible      (out_visible),
    .out_last_of_item (out_last_of_item),
    .out_line_done    (out_line_done)
  );

endmodule

[design/tlr_checker.sv]
// ----------------------------------------------------------------------------
// tlr_checker
// Port-level checks for the thick line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module tlr_checker import tlr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_pixel_x,
  input logic [PIX_W-1:0] out_pixel_color,
  input logic             out_last_of_item,
  input logic             out_line_done
);

  // stalled pixel holds its x coordinate
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x))
    else $error("stalled output pixel changed");

  // one transaction at a time: no new input while pixels are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while pixels pending");

  // a brush is emitted without gaps
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_item |=> out_valid)
    else $error("gap inside a brush");

  // color and done flag stay fixed within one brush
  a_item_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_item |=>
      out_pixel_color == $past(out_pixel_color) &&
      out_line_done == $past(out_line_done))
    else $error("color or done flag changed inside a brush");

endmodule

bind thick_line_rasterizer tlr_checker u_tlr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pixel_x      (out_pixel_x),
  .out_pixel_color  (out_pixel_color),
  .out_last_of_item (out_last_of_item),
  .out_line_done    (out_line_done)
);
